/* src/gse_pkg.sv */
// Shared types and constants for the grid successor expander.
`default_nettype none
package gse_pkg;

    localparam int unsigned COORD_W = 10;
    localparam int unsigned SIDE_W  = 11;
    localparam int unsigned COST_W  = 4;
    localparam int unsigned HEUR_W  = 14;
    localparam int unsigned DIRC_W  = 3;
    localparam int unsigned NDIR    = 8;
    localparam int unsigned CIDX_W  = 2;

    localparam logic [SIDE_W-1:0] SIDE_MAX   = 11'd1024;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd10;

    localparam logic [COST_W-1:0] COST_UNIT     = 4'd1;
    localparam logic [COST_W-1:0] COST_STRAIGHT = 4'd10;
    localparam logic [COST_W-1:0] COST_DIAG     = 4'd14;

    typedef enum logic [CIDX_W-1:0] {
        CFG_GRID_SIDE   = 2'd0,
        CFG_OCTILE_MODE = 2'd1,
        CFG_GOAL_X      = 2'd2,
        CFG_GOAL_Y      = 2'd3
    } t_cfg_idx;

    typedef enum logic [DIRC_W-1:0] {
        DIR_W  = 3'd0,
        DIR_E  = 3'd1,
        DIR_S  = 3'd2,
        DIR_N  = 3'd3,
        DIR_SW = 3'd4,
        DIR_SE = 3'd5,
        DIR_NE = 3'd6,
        DIR_NW = 3'd7
    } t_dir;

    typedef struct packed {
        logic [SIDE_W-1:0]  side;
        logic               octile;
        logic [COORD_W-1:0] goal_x;
        logic [COORD_W-1:0] goal_y;
    } t_cfg;

    typedef struct packed {
        logic [COST_W-1:0]  cost;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        t_dir               dir;
        logic               last;
    } t_meta;

endpackage
`default_nettype wire

/* src/gse_in_if.sv */
// Input channel: one cell to expand per word.
`default_nettype none
interface gse_in_if;
    import gse_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    modport source (output valid, output cur_x, output cur_y, input ready);
    modport sink   (input valid, input cur_x, input cur_y, output ready);
endinterface
`default_nettype wire

/* src/gse_out_if.sv */
// Output channel: one neighbor result per word.
`default_nettype none
interface gse_out_if;
    import gse_pkg::*;
    logic               valid;
    logic               ready;
    logic [COST_W-1:0]  move_cost;
    logic [HEUR_W-1:0]  heur_dist;
    logic [COORD_W-1:0] succ_x;
    logic [COORD_W-1:0] succ_y;
    logic [DIRC_W-1:0]  direction;
    logic               last_succ;
    modport source (output valid, output move_cost, output heur_dist, output succ_x,
                    output succ_y, output direction, output last_succ, input ready);
    modport sink   (input valid, input move_cost, input heur_dist, input succ_x,
                    input succ_y, input direction, input last_succ, output ready);
endinterface
`default_nettype wire

/* src/gse_seq.sv */
// Direction sequencer: holds one cell and issues one in-bounds neighbor per cycle while i_adv is high.
`default_nettype none
module gse_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire gse_pkg::t_cfg i_cfg,
    gse_in_if.sink             i_in,
    input  wire logic          i_adv,
    output gse_pkg::t_meta     o_cand,
    output logic               o_cand_valid
);
    import gse_pkg::*;

    logic               r_v;
    logic [NDIR-1:0]    r_mask;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;

    logic [NDIR-1:0]    n_mask_in;
    logic [NDIR-1:0]    pick;
    logic [DIRC_W-1:0]  pick_idx;
    logic               fire;
    logic               last;
    logic               take;
    logic               w, e, s, n;
    logic [SIDE_W-1:0]  side_eff;
    logic [COORD_W-1:0] xm, xp, ym, yp;

    always_comb begin
        side_eff = (i_cfg.side > SIDE_MAX) ? SIDE_MAX : i_cfg.side;
        w = (i_in.cur_x != '0);
        s = (i_in.cur_y != '0);
        e = ({1'b0, i_in.cur_x} + SIDE_W'(1)) < side_eff;
        n = ({1'b0, i_in.cur_y} + SIDE_W'(1)) < side_eff;
        n_mask_in = {i_cfg.octile & w & n, i_cfg.octile & e & n,
                     i_cfg.octile & e & s, i_cfg.octile & w & s, n, s, e, w};
    end

    always_comb begin
        pick = r_mask & (~r_mask + NDIR'(1));
        pick_idx = '0;
        for (int i = 0; i < NDIR; i++) begin
            if (pick[i]) pick_idx = DIRC_W'(i);
        end
        last = ((r_mask & ~pick) == '0);
        fire = r_v && i_adv;
        take = !r_v || (fire && last);
    end

    assign i_in.ready = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (take && i_in.valid) begin
            r_v <= (n_mask_in != '0);
        end else if (fire && last) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_in.valid) begin
            r_mask <= n_mask_in;
            r_x    <= i_in.cur_x;
            r_y    <= i_in.cur_y;
        end else if (fire) begin
            r_mask <= r_mask & ~pick;
        end
    end

    always_comb begin
        xm = r_x - COORD_W'(1);
        xp = r_x + COORD_W'(1);
        ym = r_y - COORD_W'(1);
        yp = r_y + COORD_W'(1);
        o_cand.dir  = t_dir'(pick_idx);
        o_cand.last = last;
        o_cand.cost = (pick_idx >= DIRC_W'(DIR_SW)) ? COST_DIAG :
                      (i_cfg.octile ? COST_STRAIGHT : COST_UNIT);
        o_cand.x = r_x;
        o_cand.y = r_y;
        unique case (t_dir'(pick_idx))
            DIR_W:  o_cand.x = xm;
            DIR_E:  o_cand.x = xp;
            DIR_S:  o_cand.y = ym;
            DIR_N:  o_cand.y = yp;
            DIR_SW: begin o_cand.x = xm; o_cand.y = ym; end
            DIR_SE: begin o_cand.x = xp; o_cand.y = ym; end
            DIR_NE: begin o_cand.x = xp; o_cand.y = yp; end
            DIR_NW: begin o_cand.x = xm; o_cand.y = yp; end
            default: begin o_cand.x = r_x; o_cand.y = r_y; end
        endcase
        o_cand_valid = r_v;
    end

endmodule
`default_nettype wire

/* src/grid_successor_expander.sv */
// Top level of the grid successor expander: config registers and heuristic pipeline.
`default_nettype none
// Expands one grid cell per input word into its in-bounds neighbors, one result word per
// cycle while the output accepts, in the order W, E, S, N and, in octile mode, SW, SE,
// NE, NW; the final word of a cell carries last_succ. A cell has up to four neighbors in
// unit mode and up to eight in octile mode, and the sequencer accepts the next cell as it
// issues the last neighbor of the current one, so the sustained rate is one result word
// per clock. Results pass through a four-stage heuristic pipeline that stalls cleanly
// from the output side. Configuration is written through a plain indexed write port while
// the block is idle; the user must keep to this, the block itself does not enforce it.
module grid_successor_expander (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    gse_in_if.sink                              i_in,
    gse_out_if.source                           o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [gse_pkg::CIDX_W-1:0]     i_cfg_idx,
    input  wire logic [gse_pkg::SIDE_W-1:0]     i_cfg_data
);
    import gse_pkg::*;

    logic [SIDE_W-1:0]  r_side;
    logic               r_oct;
    logic [COORD_W-1:0] r_gx;
    logic [COORD_W-1:0] r_gy;
    t_cfg               cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_RESET;
            r_oct  <= 1'b0;
            r_gx   <= '0;
            r_gy   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_SIDE:   r_side <= i_cfg_data;
                CFG_OCTILE_MODE: r_oct  <= i_cfg_data[0];
                CFG_GOAL_X:      r_gx   <= i_cfg_data[COORD_W-1:0];
                CFG_GOAL_Y:      r_gy   <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = '{side: r_side, octile: r_oct, goal_x: r_gx, goal_y: r_gy};

    t_meta cand;
    logic  cand_valid;
    logic  adv1, adv2, adv3, adv4;

    gse_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in         (i_in),
        .i_adv        (adv1),
        .o_cand       (cand),
        .o_cand_valid (cand_valid)
    );

    logic               r_v1, r_v2, r_v3, r_v4;
    t_meta              r_m1, r_m2, r_m3, r_m4;
    logic [COORD_W-1:0] r_dx, r_dy;
    logic [COORD_W-1:0] r_hi, r_lo;
    logic [HEUR_W-1:0]  r_man;
    logic [HEUR_W-1:0]  r_heur;

    assign adv4 = !r_v4 || o_out.ready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= cand_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    // stage 1: neighbor coordinates
    always_ff @(posedge i_clk) begin
        if (adv1) r_m1 <= cand;
    end

    // stage 2: distances to goal
    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_m2 <= r_m1;
            r_dx <= (r_m1.x >= r_gx) ? r_m1.x - r_gx : r_gx - r_m1.x;
            r_dy <= (r_m1.y >= r_gy) ? r_m1.y - r_gy : r_gy - r_m1.y;
        end
    end

    // stage 3: max / min and Manhattan sum
    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_m3  <= r_m2;
            r_hi  <= (r_dx > r_dy) ? r_dx : r_dy;
            r_lo  <= (r_dx > r_dy) ? r_dy : r_dx;
            r_man <= HEUR_W'(r_dx) + HEUR_W'(r_dy);
        end
    end

    // stage 4: octile 10*hi + 4*lo or, in unit mode, the Manhattan sum, output register
    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_m4   <= r_m3;
            r_heur <= r_oct ? (HEUR_W'(r_hi) << 3) + (HEUR_W'(r_hi) << 1)
                              + (HEUR_W'(r_lo) << 2)
                            : r_man;
        end
    end

    assign o_out.valid     = r_v4;
    assign o_out.move_cost = r_m4.cost;
    assign o_out.heur_dist = r_heur;
    assign o_out.succ_x    = r_m4.x;
    assign o_out.succ_y    = r_m4.y;
    assign o_out.direction = DIRC_W'(r_m4.dir);
    assign o_out.last_succ = r_m4.last;

`ifndef SYNTHESIS
    a_unit_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !r_oct |-> o_out.move_cost == COST_UNIT)
        else $error("unit mode word with non-unit cost");

    a_unit_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !r_oct |-> o_out.direction < DIRC_W'(DIR_SW))
        else $error("diagonal word in unit mode");

    a_diag_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.direction >= DIRC_W'(DIR_SW) |-> o_out.move_cost == COST_DIAG)
        else $error("diagonal word with wrong cost");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !adv4 |=> r_v3 && $stable(r_man))
        else $error("stage 3 lost data under stall");
`endif

endmodule
`default_nettype wire
